@@ design/wced_pkg.sv @@
// ----------------------------------------------------------------------------
// Weight change event detector package
// Shared types and constants for the detector core and its register file.
// ----------------------------------------------------------------------------
`default_nettype none

package wced_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned WEIGHT_W = 24;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CHANGE_W = 25;
  localparam int unsigned SLOPE_W  = 16;
  localparam int unsigned SETTLE_W = 16;
  localparam int unsigned SPIKE_W  = 23;
  localparam int unsigned PROD_W   = SLOPE_W + TIME_W;

  localparam logic [1:0] REG_SLOPE_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_SETTLE_TIME_MS  = 2'd1;
  localparam logic [1:0] REG_SPIKE_THRESHOLD = 2'd2;

  localparam logic [SLOPE_W-1:0]  SLOPE_THRESHOLD_RST = 16'd500;
  localparam logic [SETTLE_W-1:0] SETTLE_TIME_MS_RST  = 16'd200;
  localparam logic [SPIKE_W-1:0]  SPIKE_THRESHOLD_RST = 23'd500;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_STARTED = 2'd1,
    ST_NOISE   = 2'd2,
    ST_REPORT  = 2'd3
  } detector_state_e;

  typedef struct packed {
    logic [SLOPE_W-1:0]  slope_threshold;
    logic [SETTLE_W-1:0] settle_time_ms;
    logic [SPIKE_W-1:0]  spike_threshold;
  } cfg_t;

endpackage

`default_nettype wire

@@ design/wced_regs.sv @@
// ----------------------------------------------------------------------------
// Weight change event detector register file
// APB-style configuration port holding the slope, settle and spike settings.
// ----------------------------------------------------------------------------
`default_nettype none

module wced_regs
  import wced_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_SLOPE_THRESHOLD: cfg_d.slope_threshold = pwdata[SLOPE_W-1:0];
        REG_SETTLE_TIME_MS:  cfg_d.settle_time_ms  = pwdata[SETTLE_W-1:0];
        REG_SPIKE_THRESHOLD: cfg_d.spike_threshold = pwdata[SPIKE_W-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slope_threshold <= SLOPE_THRESHOLD_RST;
      cfg_q.settle_time_ms  <= SETTLE_TIME_MS_RST;
      cfg_q.spike_threshold <= SPIKE_THRESHOLD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SLOPE_THRESHOLD: prdata = {{(APB_DATA_W-SLOPE_W){1'b0}}, cfg_q.slope_threshold};
      REG_SETTLE_TIME_MS:  prdata = {{(APB_DATA_W-SETTLE_W){1'b0}}, cfg_q.settle_time_ms};
      REG_SPIKE_THRESHOLD: prdata = {{(APB_DATA_W-SPIKE_W){1'b0}}, cfg_q.spike_threshold};
      default:             prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ design/weight_change_event_detector_core.sv @@
// Datapath: a sample beat is held in the input register until it is processed,
// and any result is presented from the output register.
// Throughput: one sample beat per cycle while the output is not stalled; the
// 16x32 slope multiply and event state machine sit between the two registers.
// Reset: asynchronous, active low; the detector returns to idle, all history
// registers clear and the settings take their default values.
// ----------------------------------------------------------------------------
// Weight change event detector core
// Tracks weight slope over timestamped samples and reports settled changes.
// ----------------------------------------------------------------------------
`default_nettype none

module weight_change_event_detector_core
  import wced_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [APB_ADDR_W-1:0]      paddr,
  input  wire logic [APB_DATA_W-1:0]      pwdata,
  output logic      [APB_DATA_W-1:0]      prdata,
  output logic                            pready,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic signed [WEIGHT_W-1:0] weight_sample_i,
  input  wire logic        [TIME_W-1:0]   sample_time_ms_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [CHANGE_W-1:0]      weight_change_o
);

  cfg_t cfg;

  wced_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic                       in_valid_q;
  logic signed [WEIGHT_W-1:0] w_q;
  logic        [TIME_W-1:0]   t_q;

  detector_state_e            state_q, state_d;
  logic signed [WEIGHT_W-1:0] last_weight_q, last_weight_d;
  logic signed [WEIGHT_W-1:0] older_weight_q, older_weight_d;
  logic        [TIME_W-1:0]   last_time_q, last_time_d;
  logic        [TIME_W-1:0]   high_slope_time_q, high_slope_time_d;
  logic signed [WEIGHT_W-1:0] weight_before_q, weight_before_d;
  logic signed [WEIGHT_W-1:0] weight_settled_q, weight_settled_d;

  logic                       out_valid_q;
  logic signed [CHANGE_W-1:0] change_q;

  logic                       in_accept;
  logic                       out_free;
  logic                       proc;
  logic                       emit;

  logic        [TIME_W-1:0]   dt;
  logic        [TIME_W-1:0]   quiet_time;
  logic signed [CHANGE_W-1:0] step_diff;
  logic        [CHANGE_W-1:0] step_abs;
  logic signed [CHANGE_W-1:0] spike_diff;
  logic        [CHANGE_W-1:0] spike_abs;
  logic        [PROD_W-1:0]   slope_limit;
  logic                       high_slope;
  logic                       settled;
  logic signed [CHANGE_W-1:0] change_val;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      w_q <= weight_sample_i;
      t_q <= sample_time_ms_i;
    end
  end

  always_comb begin
    dt          = t_q - last_time_q;
    step_diff   = CHANGE_W'(w_q) - CHANGE_W'(last_weight_q);
    step_abs    = step_diff[CHANGE_W-1] ? CHANGE_W'(-step_diff) : CHANGE_W'(step_diff);
    slope_limit = PROD_W'(cfg.slope_threshold) * PROD_W'(dt);
    high_slope  = PROD_W'(step_abs) > slope_limit;

    high_slope_time_d = high_slope ? t_q : high_slope_time_q;
    quiet_time        = t_q - high_slope_time_d;
    settled           = quiet_time > TIME_W'(cfg.settle_time_ms);

    spike_diff = CHANGE_W'(weight_before_q) - CHANGE_W'(w_q);
    spike_abs  = spike_diff[CHANGE_W-1] ? CHANGE_W'(-spike_diff) : CHANGE_W'(spike_diff);
    change_val = CHANGE_W'(weight_settled_q) - CHANGE_W'(weight_before_q);

    state_d          = state_q;
    weight_before_d  = weight_before_q;
    weight_settled_d = weight_settled_q;
    emit             = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (high_slope) begin
          weight_before_d = older_weight_q;
          state_d         = ST_STARTED;
        end
      end
      ST_STARTED: begin
        if (settled) begin
          weight_settled_d = w_q;
          if (spike_abs < CHANGE_W'(cfg.spike_threshold)) begin
            state_d = ST_NOISE;
          end else begin
            state_d = ST_REPORT;
          end
        end
      end
      ST_NOISE: begin
        state_d = ST_IDLE;
      end
      ST_REPORT: begin
        emit    = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    older_weight_d = last_weight_q;
    last_weight_d  = w_q;
    last_time_d    = t_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      last_weight_q     <= '0;
      older_weight_q    <= '0;
      last_time_q       <= '0;
      high_slope_time_q <= '0;
      weight_before_q   <= '0;
      weight_settled_q  <= '0;
    end else if (proc) begin
      state_q           <= state_d;
      last_weight_q     <= last_weight_d;
      older_weight_q    <= older_weight_d;
      last_time_q       <= last_time_d;
      high_slope_time_q <= high_slope_time_d;
      weight_before_q   <= weight_before_d;
      weight_settled_q  <= weight_settled_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && proc && emit) begin
      change_q <= change_val;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign weight_change_o = change_q;

endmodule

`default_nettype wire

@@ design/wced_checker.sv @@
// ----------------------------------------------------------------------------
// Weight change event detector port checker
// Watches the top level's ports and checks handshake and result spacing.
// ----------------------------------------------------------------------------
`default_nettype none

module wced_checker
  import wced_pkg::*;
(
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic signed [CHANGE_W-1:0] weight_change_o
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result beat withdrawn while stalled.");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(weight_change_o))
    else $error("Result beat changed while stalled.");

  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled without a stalled result beat.");

  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("Result beat followed directly by another result beat.");

endmodule

bind weight_change_event_detector_core wced_checker u_wced_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .weight_change_o (weight_change_o)
);

`default_nettype wire
